// ----- sv/tgs_pkg.sv -----
// Shared types, widths and helpers for the trilateration gradient step unit.
package tgs_pkg;

	// Position and range widths
	localparam int unsigned POS_W   = 36;
	localparam int unsigned RANGE_W = 32;
	localparam int unsigned STEP_W  = 16;
	localparam int unsigned IDX_W   = 3;

	// Shared unit: magnitude operands, double-width products, one bit per cycle
	localparam int unsigned MAG_W  = 39;
	localparam int unsigned PROD_W = 2 * MAG_W;
	localparam int unsigned REM_W  = MAG_W + 3;
	localparam int unsigned CNT_W  = 6;
	localparam logic [CNT_W-1:0] ITER = CNT_W'(MAG_W);

	// Wide signed widths for sums and the position update
	localparam int unsigned SUM_W = 41;
	localparam int unsigned UPD_W = 42;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_A0_EAST  = 3'd0;
	localparam logic [IDX_W-1:0] REG_A0_NORTH = 3'd1;
	localparam logic [IDX_W-1:0] REG_A1_EAST  = 3'd2;
	localparam logic [IDX_W-1:0] REG_A1_NORTH = 3'd3;
	localparam logic [IDX_W-1:0] REG_A2_EAST  = 3'd4;
	localparam logic [IDX_W-1:0] REG_A2_NORTH = 3'd5;
	localparam logic [IDX_W-1:0] REG_STEP     = 3'd6;

	// Item kinds
	localparam logic FUNC_STEP = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_SQRT = 2'd1,
		OP_DIV  = 2'd2
	} tgs_op_t;

	typedef struct packed {
		logic    start;
		tgs_op_t op;
	} tgs_cmd_t;

	typedef struct packed {
		logic             sat;
		logic [POS_W-1:0] val;
	} tgs_clamp_t;

	// Clamp a wide signed position to the 36-bit range
	function automatic tgs_clamp_t clamp_pos(input logic signed [UPD_W-1:0] r);
		tgs_clamp_t c;
		logic signed [UPD_W-1:0] pmax;
		logic signed [UPD_W-1:0] pmin;
		pmax = UPD_W'({1'b0, {(POS_W-1){1'b1}}});
		pmin = -(UPD_W'({1'b1, {(POS_W-1){1'b0}}}));
		if (r > pmax) begin
			c.sat = 1'b1;
			c.val = {1'b0, {(POS_W-1){1'b1}}};
		end else if (r < pmin) begin
			c.sat = 1'b1;
			c.val = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			c.sat = 1'b0;
			c.val = r[POS_W-1:0];
		end
		return c;
	endfunction

endpackage

// ----- sv/trilateration_gradient_step_unit.sv -----
// Top level: configuration, estimate state and the step sequencer around the shared unit.
//
//  channel   dir  handshake            payload
//  in        in   in_valid/in_ready    func, range0..2, start_east, start_north
//  out       out  out_valid/out_ready  pos_east, pos_north, coincident_anchor, saturated
//  cfg       in   cfg_we               cfg_index, cfg_data
//
// A step item runs 23 operations on the shared unit (per anchor two squares, a root,
// two products, two quotients; then two scalings), each from a start strobe through
// its bit-serial iterations to done; an anchor on the estimate skips its two products
// and two quotients.
// Reset clears the anchors, step size and estimate to zero.
// in_ready is high only while idle; a finished result waits in the output register,
// and the next item is taken while it waits. A stalled output holds the sequencer
// only at its last state.
module trilateration_gradient_step_unit import tgs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [POS_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic [RANGE_W-1:0]      range0,
	input  logic [RANGE_W-1:0]      range1,
	input  logic [RANGE_W-1:0]      range2,
	input  logic signed [POS_W-1:0] start_east,
	input  logic signed [POS_W-1:0] start_north,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [POS_W-1:0] pos_east,
	output logic signed [POS_W-1:0] pos_north,
	output logic                    coincident_anchor,
	output logic                    saturated
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_DIFF = 13'b0000000000010,
		S_SQE  = 13'b0000000000100,
		S_SQN  = 13'b0000000001000,
		S_ROOT = 13'b0000000010000,
		S_CHK  = 13'b0000000100000,
		S_PE   = 13'b0000001000000,
		S_QE   = 13'b0000010000000,
		S_PN   = 13'b0000100000000,
		S_QN   = 13'b0001000000000,
		S_UE   = 13'b0010000000000,
		S_UN   = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic   wait_q;
	logic [1:0] anc_q;

	logic signed [POS_W-1:0] anc_e_q [3];
	logic signed [POS_W-1:0] anc_n_q [3];
	logic [STEP_W-1:0]       step_q;
	logic [RANGE_W-1:0]      range_q [3];
	logic signed [POS_W-1:0] est_e_q;
	logic signed [POS_W-1:0] est_n_q;

	logic              de_neg_q;
	logic              dn_neg_q;
	logic              diff_neg_q;
	logic [MAG_W-1:0]  de_mag_q;
	logic [MAG_W-1:0]  dn_mag_q;
	logic [MAG_W-1:0]  diff_mag_q;
	logic [MAG_W-1:0]  k_q;
	logic [PROD_W-1:0] sq_q;
	logic signed [SUM_W-1:0] se_q;
	logic signed [SUM_W-1:0] sn_q;
	logic              coin_q;
	logic              sat_q;

	logic                    out_valid_q;
	logic signed [POS_W-1:0] pos_e_q;
	logic signed [POS_W-1:0] pos_n_q;
	logic                    coin_out_q;
	logic                    sat_out_q;

	tgs_cmd_t          cmd;
	logic [PROD_W-1:0] opa;
	logic [MAG_W-1:0]  opb;
	logic              eng_done;
	logic [PROD_W-1:0] eng_prod;
	logic [MAG_W-1:0]  eng_res;

	logic signed [POS_W:0]   de_w;
	logic signed [POS_W:0]   dn_w;
	logic signed [MAG_W:0]   diff_w;
	logic signed [SUM_W-1:0] term_w;
	logic [MAG_W-1:0]        se_mag;
	logic [MAG_W-1:0]        sn_mag;
	logic signed [UPD_W-1:0] upd_w;
	logic [UPD_W-1:0]        dmag_w;
	tgs_clamp_t              clamp_w;
	logic                    last_anc;
	logic                    in_xfer;

	tgs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.done   (eng_done),
		.prod   (eng_prod),
		.res    (eng_res)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign last_anc = (anc_q == 2'd2);

	// Differences to the current anchor and their magnitudes
	always_comb begin
		de_w   = {est_e_q[POS_W-1], est_e_q} - {anc_e_q[anc_q][POS_W-1], anc_e_q[anc_q]};
		dn_w   = {est_n_q[POS_W-1], est_n_q} - {anc_n_q[anc_q][POS_W-1], anc_n_q[anc_q]};
		diff_w = $signed({{(MAG_W+1-RANGE_W){1'b0}}, range_q[anc_q]}) - $signed({1'b0, k_q});
		term_w = $signed({{(SUM_W-MAG_W){1'b0}}, eng_res});
		if ((state_q == S_QE && (diff_neg_q != de_neg_q)) ||
		    (state_q == S_QN && (diff_neg_q != dn_neg_q))) begin
			term_w = -term_w;
		end
		se_mag = se_q[SUM_W-1] ? MAG_W'(-se_q) : MAG_W'(se_q);
		sn_mag = sn_q[SUM_W-1] ? MAG_W'(-sn_q) : MAG_W'(sn_q);
	end

	// Scaled update of the coordinate being finished, then clamp
	always_comb begin
		dmag_w = UPD_W'(eng_prod[STEP_W +: (UPD_W-1)]);
		if (state_q == S_UE) begin
			upd_w = UPD_W'(est_e_q) + (se_q[SUM_W-1] ? -$signed(dmag_w) : $signed(dmag_w));
		end else begin
			upd_w = UPD_W'(est_n_q) + (sn_q[SUM_W-1] ? -$signed(dmag_w) : $signed(dmag_w));
		end
		clamp_w = clamp_pos(upd_w);
	end

	// Operand selection and start strobe for the shared unit
	always_comb begin
		cmd.start = 1'b0;
		cmd.op    = OP_MUL;
		opa       = '0;
		opb       = '0;
		unique case (state_q)
			S_SQE: begin
				cmd.start = !wait_q;
				opa = PROD_W'(de_mag_q);
				opb = de_mag_q;
			end
			S_SQN: begin
				cmd.start = !wait_q;
				opa = PROD_W'(dn_mag_q);
				opb = dn_mag_q;
			end
			S_ROOT: begin
				cmd.start = !wait_q;
				cmd.op = OP_SQRT;
				opa = sq_q;
			end
			S_PE: begin
				cmd.start = !wait_q;
				opa = PROD_W'(diff_mag_q);
				opb = de_mag_q;
			end
			S_PN: begin
				cmd.start = !wait_q;
				opa = PROD_W'(diff_mag_q);
				opb = dn_mag_q;
			end
			S_QE, S_QN: begin
				cmd.start = !wait_q;
				cmd.op = OP_DIV;
				opa = sq_q;
				opb = k_q;
			end
			S_UE: begin
				cmd.start = !wait_q;
				opa = PROD_W'({step_q, 1'b0});
				opb = se_mag;
			end
			S_UN: begin
				cmd.start = !wait_q;
				opa = PROD_W'({step_q, 1'b0});
				opb = sn_mag;
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				anc_e_q[i] <= '0;
				anc_n_q[i] <= '0;
			end
			step_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A0_EAST:  anc_e_q[0] <= cfg_data;
				REG_A0_NORTH: anc_n_q[0] <= cfg_data;
				REG_A1_EAST:  anc_e_q[1] <= cfg_data;
				REG_A1_NORTH: anc_n_q[1] <= cfg_data;
				REG_A2_EAST:  anc_e_q[2] <= cfg_data;
				REG_A2_NORTH: anc_n_q[2] <= cfg_data;
				REG_STEP:     step_q     <= cfg_data[STEP_W-1:0];
				default:      step_q     <= step_q;
			endcase
		end
	end

	// Sequencer and estimate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= 1'b0;
			anc_q   <= '0;
			est_e_q <= '0;
			est_n_q <= '0;
			coin_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				wait_q <= 1'b1;
			end else if (eng_done) begin
				wait_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						coin_q <= 1'b0;
						sat_q  <= 1'b0;
						anc_q  <= '0;
						if (func == FUNC_LOAD) begin
							est_e_q <= start_east;
							est_n_q <= start_north;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIFF;
						end
					end
				end
				S_DIFF: state_q <= S_SQE;
				S_SQE:  if (eng_done) state_q <= S_SQN;
				S_SQN:  if (eng_done) state_q <= S_ROOT;
				S_ROOT: if (eng_done) state_q <= S_CHK;
				S_CHK: begin
					if (k_q == '0) begin
						coin_q <= 1'b1;
						if (last_anc) begin
							state_q <= S_UE;
						end else begin
							anc_q   <= anc_q + 1'b1;
							state_q <= S_DIFF;
						end
					end else begin
						state_q <= S_PE;
					end
				end
				S_PE: if (eng_done) state_q <= S_QE;
				S_QE: if (eng_done) state_q <= S_PN;
				S_PN: if (eng_done) state_q <= S_QN;
				S_QN: begin
					if (eng_done) begin
						if (last_anc) begin
							state_q <= S_UE;
						end else begin
							anc_q   <= anc_q + 1'b1;
							state_q <= S_DIFF;
						end
					end
				end
				S_UE: begin
					if (eng_done) begin
						est_e_q <= clamp_w.val;
						sat_q   <= sat_q | clamp_w.sat;
						state_q <= S_UN;
					end
				end
				S_UN: begin
					if (eng_done) begin
						est_n_q <= clamp_w.val;
						sat_q   <= sat_q | clamp_w.sat;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of a step
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			range_q[0] <= range0;
			range_q[1] <= range1;
			range_q[2] <= range2;
			se_q       <= '0;
			sn_q       <= '0;
		end
		if (state_q == S_DIFF) begin
			de_neg_q <= de_w[POS_W];
			dn_neg_q <= dn_w[POS_W];
			de_mag_q <= MAG_W'(de_w[POS_W] ? -de_w : de_w);
			dn_mag_q <= MAG_W'(dn_w[POS_W] ? -dn_w : dn_w);
		end
		if (state_q == S_CHK) begin
			diff_neg_q <= diff_w[MAG_W];
			diff_mag_q <= MAG_W'(diff_w[MAG_W] ? -diff_w : diff_w);
		end
		if (eng_done) begin
			unique case (state_q)
				S_SQE:        sq_q <= eng_prod;
				S_SQN:        sq_q <= sq_q + eng_prod;
				S_ROOT:       k_q  <= eng_res;
				S_PE, S_PN:   sq_q <= eng_prod;
				S_QE:         se_q <= se_q + term_w;
				S_QN:         sn_q <= sn_q + term_w;
				default:      k_q  <= k_q;
			endcase
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			pos_e_q    <= est_e_q;
			pos_n_q    <= est_n_q;
			coin_out_q <= coin_q;
			sat_out_q  <= sat_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign pos_east          = pos_e_q;
	assign pos_north         = pos_n_q;
	assign coincident_anchor = coin_out_q;
	assign saturated         = sat_out_q;

endmodule

// ----- sv/tgs_engine.sv -----
// Shared bit-serial unit: shift-add multiply, floor square root, restoring divide.
module tgs_engine import tgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tgs_cmd_t          cmd,
	input  logic [PROD_W-1:0] opa,
	input  logic [MAG_W-1:0]  opb,
	output logic              done,
	output logic [PROD_W-1:0] prod,
	output logic [MAG_W-1:0]  res
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	tgs_op_t           op_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] sh_q;
	logic [MAG_W-1:0]  mb_q;
	logic [REM_W-1:0]  rem_q;
	logic [MAG_W-1:0]  res_q;

	logic [PROD_W-1:0] acc_d;
	logic [PROD_W-1:0] sh_d;
	logic [MAG_W-1:0]  mb_d;
	logic [REM_W-1:0]  rem_d;
	logic [MAG_W-1:0]  res_d;
	logic [REM_W-1:0]  sq_r2;
	logic [REM_W-1:0]  sq_trial;
	logic [MAG_W:0]    dv_r2;
	logic [MAG_W:0]    dv_den;

	// One iteration of the active operation
	always_comb begin
		acc_d    = acc_q;
		sh_d     = sh_q;
		mb_d     = mb_q;
		rem_d    = rem_q;
		res_d    = res_q;
		sq_r2    = {rem_q[REM_W-3:0], sh_q[PROD_W-1 -: 2]};
		sq_trial = {1'b0, res_q, 2'b01};
		dv_r2    = {rem_q[MAG_W-1:0], sh_q[PROD_W-1]};
		dv_den   = {1'b0, mb_q};
		unique case (op_q)
			OP_MUL: begin
				acc_d = acc_q + (mb_q[0] ? sh_q : '0);
				sh_d  = sh_q << 1;
				mb_d  = mb_q >> 1;
			end
			OP_SQRT: begin
				if (sq_r2 >= sq_trial) begin
					rem_d = sq_r2 - sq_trial;
					res_d = {res_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_d = sq_r2;
					res_d = {res_q[MAG_W-2:0], 1'b0};
				end
				sh_d = sh_q << 2;
			end
			OP_DIV: begin
				if (dv_r2 >= dv_den) begin
					rem_d = REM_W'(dv_r2 - dv_den);
					res_d = {res_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_d = REM_W'(dv_r2);
					res_d = {res_q[MAG_W-2:0], 1'b0};
				end
				sh_d = sh_q << 1;
			end
			default: begin
				acc_d = acc_q;
			end
		endcase
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER;
				op_q   <= cmd.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands on start, iterate while busy
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			res_q <= '0;
			mb_q  <= opb;
			unique case (cmd.op)
				OP_DIV: begin
					rem_q <= REM_W'(opa[PROD_W-1:MAG_W]);
					sh_q  <= {opa[MAG_W-1:0], {MAG_W{1'b0}}};
				end
				default: begin
					rem_q <= '0;
					sh_q  <= opa;
				end
			endcase
		end else if (busy_q) begin
			acc_q <= acc_d;
			sh_q  <= sh_d;
			mb_q  <= mb_d;
			rem_q <= rem_d;
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign res  = res_q;

endmodule
